// ===== design/rrfp_pkg.sv =====
// rrfp_pkg: shared types, constants and character helpers for the reply frame parser
// no dependencies; used by rrfp_parse and rotator_reply_frame_parser

package rrfp_pkg;

    // default count of fraction digits kept in the fixed-point value
    localparam int FRACTION_DIGITS_DEF = 4;

    localparam int ACC_W = 31;                      // magnitude width, limit is 2^31-1
    localparam int POW_W = 20;                      // wide enough for 10^6
    localparam int SEEN_W = 3;
    localparam logic [ACC_W-1:0] MAG_LIMIT = {ACC_W{1'b1}};

    // reciprocal of ten for a 31-bit dividend: q = (n * RECIP10) >> RECIP10_SHIFT
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP10_SHIFT = 35;

    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_COMMA1,
        PH_VERB,
        PH_COMMA2,
        PH_NUMSTART,
        PH_INTFIRST,
        PH_INT,
        PH_FRACFIRST,
        PH_FRAC,
        PH_STATUS,
        PH_TRAIL,
        PH_FAIL
    } rrfp_phase_t;

    // snapshot of a finished frame, handed from the parser to the output stage
    typedef struct packed {
        logic             matched;
        logic [7:0]       axis;
        logic [7:0]       verb;
        logic [7:0]       status;
        logic [ACC_W-1:0] mag;
        logic             neg;
        logic             ovf;
    } rrfp_final_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c == 8'h85) || (c == 8'hA0);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [SEEN_W-1:0] k);
        logic [POW_W-1:0] p;
        unique case (k)
            3'd0: p = POW_W'(1);
            3'd1: p = POW_W'(10);
            3'd2: p = POW_W'(100);
            3'd3: p = POW_W'(1000);
            3'd4: p = POW_W'(10000);
            3'd5: p = POW_W'(100000);
            3'd6: p = POW_W'(1000000);
            default: p = POW_W'(1);
        endcase
        return p;
    endfunction

endpackage

// ===== design/rrfp_parse.sv =====
// rrfp_parse: per-byte phase machine and fixed-point number accumulator
// depends on rrfp_pkg

module rrfp_parse #(
    parameter int FRACTION_DIGITS = rrfp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,       // process one byte this cycle
    input  logic [7:0]            rx_byte,
    input  logic                  frame_end,
    output rrfp_pkg::rrfp_final_t fin         // frame outcome, meaningful with step && frame_end
);
    import rrfp_pkg::*;

    localparam int SUM_W = ACC_W + 5;

    rrfp_phase_t       phase_reg, phase_next, phase_a;
    logic [7:0]        axis_reg, axis_next, axis_a;
    logic [7:0]        verb_reg, verb_next, verb_a;
    logic [7:0]        status_reg, status_next, status_a;
    logic [ACC_W-1:0]  acc_reg, acc_next, acc_a;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_a;
    logic              neg_reg, neg_next, neg_a;
    logic              ovf_reg, ovf_next, ovf_a;

    logic              take;
    logic              sel_int;
    logic [3:0]        digit;
    logic [SEEN_W-1:0] pow_idx;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  sum;
    logic              sum_over;
    logic [ACC_W-1:0]  sum_clamped;
    logic              frac_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEAD;
            axis_reg   <= '0;
            verb_reg   <= '0;
            status_reg <= '0;
            acc_reg    <= '0;
            seen_reg   <= '0;
            neg_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            axis_reg   <= axis_next;
            verb_reg   <= verb_next;
            status_reg <= status_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            neg_reg    <= neg_next;
            ovf_reg    <= ovf_next;
        end
    end

    // shared digit adder: integer digits shift the accumulator by ten first
    always_comb begin
        sel_int   = (phase_reg != PH_FRACFIRST) && (phase_reg != PH_FRAC);
        digit     = 4'(rx_byte - CH_ZERO);
        frac_room = (32'(seen_reg) < FRACTION_DIGITS);
        pow_idx   = sel_int ? SEEN_W'(FRACTION_DIGITS)
                            : SEEN_W'(FRACTION_DIGITS - 1) - seen_reg;
        base      = sel_int ? (SUM_W'(acc_reg) << 3) + (SUM_W'(acc_reg) << 1)
                            : SUM_W'(acc_reg);
        sum       = base + SUM_W'(digit) * SUM_W'(pow10(pow_idx));
        sum_over  = (sum > SUM_W'(MAG_LIMIT));
        sum_clamped = sum_over ? MAG_LIMIT : sum[ACC_W-1:0];
    end

    always_comb begin
        take     = step && (rx_byte != CH_STX) && (rx_byte != CH_CR);
        phase_a  = phase_reg;
        axis_a   = axis_reg;
        verb_a   = verb_reg;
        status_a = status_reg;
        acc_a    = acc_reg;
        seen_a   = seen_reg;
        neg_a    = neg_reg;
        ovf_a    = ovf_reg;

        if (take) begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (is_upper(rx_byte)) begin
                        axis_a  = rx_byte;
                        phase_a = PH_COMMA1;
                    end else if (!is_space(rx_byte)) begin
                        phase_a = PH_FAIL;
                    end
                end
                PH_COMMA1: phase_a = (rx_byte == CH_COMMA) ? PH_VERB : PH_FAIL;
                PH_VERB: begin
                    if (rx_byte == CH_COMMA) begin
                        phase_a = PH_FAIL;
                    end else begin
                        verb_a  = rx_byte;
                        phase_a = PH_COMMA2;
                    end
                end
                PH_COMMA2: phase_a = (rx_byte == CH_COMMA) ? PH_NUMSTART : PH_FAIL;
                PH_NUMSTART: begin
                    if (rx_byte == CH_MINUS) begin
                        neg_a   = 1'b1;
                        phase_a = PH_INTFIRST;
                    end else if (is_digit(rx_byte)) begin
                        acc_a   = sum_clamped;
                        ovf_a   = ovf_reg | sum_over;
                        phase_a = PH_INT;
                    end else begin
                        phase_a = PH_FAIL;
                    end
                end
                PH_INTFIRST: begin
                    if (is_digit(rx_byte)) begin
                        acc_a   = sum_clamped;
                        ovf_a   = ovf_reg | sum_over;
                        phase_a = PH_INT;
                    end else begin
                        phase_a = PH_FAIL;
                    end
                end
                PH_INT: begin
                    if (is_digit(rx_byte)) begin
                        acc_a = sum_clamped;
                        ovf_a = ovf_reg | sum_over;
                    end else if (rx_byte == CH_POINT) begin
                        phase_a = PH_FRACFIRST;
                    end else if (rx_byte == CH_COMMA) begin
                        phase_a = PH_STATUS;
                    end else begin
                        phase_a = PH_FAIL;
                    end
                end
                PH_FRACFIRST, PH_FRAC: begin
                    if (is_digit(rx_byte)) begin
                        // digits past the kept precision are dropped
                        if (frac_room) begin
                            acc_a  = sum_clamped;
                            ovf_a  = ovf_reg | sum_over;
                            seen_a = seen_reg + 1'b1;
                        end
                        phase_a = PH_FRAC;
                    end else if (rx_byte == CH_COMMA && phase_reg == PH_FRAC) begin
                        phase_a = PH_STATUS;
                    end else begin
                        phase_a = PH_FAIL;
                    end
                end
                PH_STATUS: begin
                    if (is_upper(rx_byte)) begin
                        status_a = rx_byte;
                        phase_a  = PH_TRAIL;
                    end else begin
                        phase_a = PH_FAIL;
                    end
                end
                PH_TRAIL: begin
                    if (!is_space(rx_byte)) begin
                        phase_a = PH_FAIL;
                    end
                end
                default: phase_a = PH_FAIL;
            endcase
        end

        fin.matched = (phase_a == PH_TRAIL);
        fin.axis    = axis_a;
        fin.verb    = verb_a;
        fin.status  = status_a;
        fin.mag     = acc_a;
        fin.neg     = neg_a;
        fin.ovf     = ovf_a;

        // the last byte of a frame returns the parse to its idle values
        if (step && frame_end) begin
            phase_next  = PH_LEAD;
            axis_next   = '0;
            verb_next   = '0;
            status_next = '0;
            acc_next    = '0;
            seen_next   = '0;
            neg_next    = 1'b0;
            ovf_next    = 1'b0;
        end else begin
            phase_next  = phase_a;
            axis_next   = axis_a;
            verb_next   = verb_a;
            status_next = status_a;
            acc_next    = acc_a;
            seen_next   = seen_a;
            neg_next    = neg_a;
            ovf_next    = ovf_a;
        end
    end

endmodule

// ===== design/rotator_reply_frame_parser.sv =====
// Rotator reply frame parser: up to one frame byte per cycle in, one result per frame out.
// The result goes through the input, finished-frame and result registers in turn.
// Throughput: one byte per cycle unless a frame end waits for room in the finished stage.
// Reset: synchronous, active-low aresetn clears the parse, tenths_mode and all stage valids.
// depends on rrfp_pkg and rrfp_parse

module rotator_reply_frame_parser #(
    parameter int FRACTION_DIGITS = rrfp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // tenths_mode register
    input  logic        cfg_we,
    input  logic        cfg_wdata,

    // frame bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // frame_end

    // one result per frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] matched, [8:1] axis_letter, [16:9] verb_char, [48:17] angle_value,
    // [56:49] status_letter, [57] value_saturated, [63:58] zero
    output logic [63:0] m_axis_tdata
);
    import rrfp_pkg::*;

    logic              tenths_mode_reg;

    // input register stage
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              in_go;

    // finished-frame stage
    logic              fin_valid_reg;
    rrfp_final_t       fin_reg;
    rrfp_final_t       fin_now;
    logic              fin_ready;

    // result register
    logic              out_valid_reg;
    logic              out_ready;
    logic              matched_reg;
    logic [7:0]        axis_reg;
    logic [7:0]        verb_reg;
    logic [31:0]       angle_reg;
    logic [7:0]        status_reg;
    logic              sat_reg;

    logic [63:0]       prod;
    logic [ACC_W-1:0]  quot;
    logic [ACC_W-1:0]  mag_sel;
    logic [31:0]       angle_now;

    // ready chain: each stage frees when its downstream takes its contents
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign fin_ready     = !fin_valid_reg || out_ready;
    // a plain byte always proceeds; a frame end needs room in the finished stage
    assign in_go         = in_valid_reg && (!in_last_reg || fin_ready);
    assign s_axis_tready = !in_valid_reg || in_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tenths_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            tenths_mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    rrfp_parse #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_go),
        .rx_byte   (in_byte_reg),
        .frame_end (in_last_reg),
        .fin       (fin_now)
    );

    // capture the outcome of a frame on its last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            fin_valid_reg <= in_go && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_ready && in_go && in_last_reg) begin
            fin_reg <= fin_now;
        end
    end

    // in tenths mode divide by ten through the reciprocal; the sign is applied in either mode
    always_comb begin
        prod      = 64'(fin_reg.mag) * 64'(RECIP10);
        quot      = ACC_W'(prod >> RECIP10_SHIFT);
        mag_sel   = tenths_mode_reg ? quot : fin_reg.mag;
        angle_now = fin_reg.neg ? (32'd0 - 32'(mag_sel)) : 32'(mag_sel);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    // a frame that does not match reports zero in every field
    always_ff @(posedge aclk) begin
        if (out_ready && fin_valid_reg) begin
            matched_reg <= fin_reg.matched;
            axis_reg    <= fin_reg.matched ? fin_reg.axis   : 8'd0;
            verb_reg    <= fin_reg.matched ? fin_reg.verb   : 8'd0;
            angle_reg   <= fin_reg.matched ? angle_now      : 32'd0;
            status_reg  <= fin_reg.matched ? fin_reg.status : 8'd0;
            sat_reg     <= fin_reg.matched && fin_reg.ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, sat_reg, status_reg, angle_reg, verb_reg, axis_reg,
                            matched_reg};

endmodule
